### rtl/trimmed_interval_profiler_core_defines.svh
// ============================================================================
// Trimmed interval profiler assertion macros
// Shared concurrent assertion forms, clocked and gated by the active-low reset.
// ============================================================================
`ifndef TRIMMED_INTERVAL_PROFILER_CORE_DEFINES_SVH
`define TRIMMED_INTERVAL_PROFILER_CORE_DEFINES_SVH

// Same-cycle implication.
`define TIP_ASSERT_IMP(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("Profiler property violated.");

// Next-cycle implication.
`define TIP_ASSERT_NXT(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("Profiler property violated.");

`endif

### rtl/tip_pkg.sv
// ============================================================================
// Trimmed interval profiler package
// Beat types, record layout, operation codes and state encodings.
// ============================================================================
package tip_pkg;

  localparam int ENTRIES_DEF = 128;
  localparam int CHAN_W      = 7;
  localparam int STAMP_W     = 64;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] OPC_BEGIN = 2'd0;
  localparam logic [1:0] OPC_END   = 2'd1;

  typedef enum logic [1:0] {
    KIND_BEGIN,
    KIND_END,
    KIND_READ
  } kind_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [CHAN_W-1:0]  channel;
    logic [STAMP_W-1:0] timestamp;
  } in_beat_t;

  typedef struct packed {
    logic [STAMP_W-1:0] call_count;
    logic [STAMP_W-1:0] trimmed_total;
    logic [STAMP_W-1:0] largest;
    logic [STAMP_W-1:0] second_largest;
    logic [STAMP_W-1:0] smallest;
    logic [STAMP_W-1:0] second_smallest;
  } out_beat_t;

  typedef struct packed {
    kind_t              kind;
    logic               hit;
    logic [CHAN_W-1:0]  channel;
    logic [STAMP_W-1:0] timestamp;
  } work_t;

  typedef struct packed {
    logic [STAMP_W-1:0] start_stamp;
    logic [STAMP_W-1:0] call_count;
    logic [STAMP_W-1:0] trimmed_total;
    logic [STAMP_W-1:0] largest;
    logic [STAMP_W-1:0] second_largest;
    logic [STAMP_W-1:0] smallest;
    logic [STAMP_W-1:0] second_smallest;
  } rec_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_LOAD,
    B_MAXS,
    B_MINS,
    B_FIN
  } back_state_t;

  typedef struct packed {
    logic clearing;
    logic finishing;
  } back_stat_t;

endpackage

### rtl/tip_chan_if.sv
// ============================================================================
// Profiler channel interface
// Valid/ready channel carrying one payload per beat.
// ============================================================================
interface tip_chan_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

### rtl/tip_ram.sv
// ============================================================================
// Profiler generic RAM
// One write port and one read port with registered read data.
// ============================================================================
module tip_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/tip_front.sv
// ============================================================================
// Profiler front end
// Accepts event beats, decodes the opcode and checks the channel range.
// ============================================================================
module tip_front #(
  parameter int ENTRIES = tip_pkg::ENTRIES_DEF
) (
  tip_chan_if.sink          in_chan,
  tip_chan_if.source        work_chan,
  input tip_pkg::back_stat_t stat
);

  tip_pkg::kind_t kind;

  always_comb begin
    unique case (in_chan.data.opcode)
      tip_pkg::OPC_BEGIN: kind = tip_pkg::KIND_BEGIN;
      tip_pkg::OPC_END:   kind = tip_pkg::KIND_END;
      default:            kind = tip_pkg::KIND_READ;
    endcase
  end

  assign in_chan.ready             = work_chan.ready && !stat.clearing;
  assign work_chan.valid           = in_chan.valid && !stat.clearing;
  assign work_chan.data.kind       = kind;
  assign work_chan.data.hit        = 32'(in_chan.data.channel) < ENTRIES;
  assign work_chan.data.channel    = in_chan.data.channel;
  assign work_chan.data.timestamp  = in_chan.data.timestamp;

endmodule

### rtl/tip_queue.sv
// ============================================================================
// Profiler work queue
// Short FIFO of decoded events between the front end and the back end.
// ============================================================================
module tip_queue (
  input  logic        clk,
  input  logic        rst_n,
  tip_chan_if.sink    push_chan,
  tip_chan_if.source  pop_chan
);

  localparam int DEPTH = tip_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  tip_pkg::work_t mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           push, pop;

  assign push_chan.ready = count_r != CW'(DEPTH);
  assign pop_chan.valid  = count_r != '0;
  assign pop_chan.data   = mem_r[rd_ptr_r];
  assign push            = push_chan.valid && push_chan.ready;
  assign pop             = pop_chan.valid && pop_chan.ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_chan.data;
    end
  end

endmodule

### rtl/tip_back.sv
// ============================================================================
// Profiler back end
// Reads the channel record, applies the event, writes back begin/end updates and returns it.
// ============================================================================
module tip_back #(
  parameter int ENTRIES = tip_pkg::ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  tip_chan_if.sink            work_chan,
  tip_chan_if.source          out_chan,
  output tip_pkg::back_stat_t stat
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RW = $bits(tip_pkg::rec_t);

  tip_pkg::back_state_t state_r, state_nxt;
  logic [AW-1:0]        clr_addr_r, clr_addr_nxt;
  tip_pkg::work_t       work_r, work_nxt;
  tip_pkg::rec_t        rec_r, rec_nxt;
  logic [63:0]          val_r, val_nxt;
  logic                 done_r, done_nxt;
  logic                 out_valid_r, out_valid_nxt;
  tip_pkg::out_beat_t   out_data_r, out_data_nxt;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [RW-1:0]        ram_wdata;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [RW-1:0]        ram_rdata;

  tip_ram #(
    .WIDTH (RW),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt       = state_r;
    clr_addr_nxt    = clr_addr_r;
    work_nxt        = work_r;
    rec_nxt         = rec_r;
    val_nxt         = val_r;
    done_nxt        = done_r;
    out_data_nxt    = out_data_r;
    out_valid_nxt   = out_valid_r && !out_chan.ready;
    ram_we          = 1'b0;
    ram_waddr       = AW'(work_r.channel);
    ram_wdata       = rec_r;
    ram_re          = 1'b0;
    ram_raddr       = AW'(work_chan.data.channel);
    work_chan.ready = 1'b0;

    unique case (state_r)
      tip_pkg::B_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(ENTRIES - 1)) begin
          state_nxt = tip_pkg::B_IDLE;
        end
      end
      tip_pkg::B_IDLE: begin
        work_chan.ready = 1'b1;
        if (work_chan.valid) begin
          work_nxt  = work_chan.data;
          rec_nxt   = '0;
          ram_re    = work_chan.data.hit;
          state_nxt = work_chan.data.hit ? tip_pkg::B_LOAD : tip_pkg::B_FIN;
        end
      end
      tip_pkg::B_LOAD: begin
        rec_nxt   = tip_pkg::rec_t'(ram_rdata);
        state_nxt = tip_pkg::B_FIN;
        unique case (work_r.kind)
          tip_pkg::KIND_BEGIN: begin
            rec_nxt.start_stamp = work_r.timestamp;
          end
          tip_pkg::KIND_END: begin
            rec_nxt.call_count = rec_nxt.call_count + 64'd1;
            val_nxt            = work_r.timestamp - rec_nxt.start_stamp;
            state_nxt          = tip_pkg::B_MAXS;
          end
          default: begin
          end
        endcase
      end
      tip_pkg::B_MAXS: begin
        done_nxt  = 1'b0;
        state_nxt = tip_pkg::B_MINS;
        if (rec_r.largest == '0) begin
          rec_nxt.largest = val_r;
          done_nxt        = 1'b1;
        end else if (rec_r.largest < val_r) begin
          rec_nxt.largest = val_r;
          val_nxt         = rec_r.largest;
        end
        if (!done_nxt) begin
          if (rec_r.second_largest == '0) begin
            rec_nxt.second_largest = val_nxt;
            done_nxt               = 1'b1;
          end else if (rec_r.second_largest < val_nxt) begin
            rec_nxt.second_largest = val_nxt;
            val_nxt                = rec_r.second_largest;
          end
        end
      end
      tip_pkg::B_MINS: begin
        state_nxt = tip_pkg::B_FIN;
        if (!done_r) begin
          if (rec_r.smallest == '0) begin
            rec_nxt.smallest = val_r;
            done_nxt         = 1'b1;
          end else if (rec_r.smallest > val_r) begin
            rec_nxt.smallest = val_r;
            val_nxt          = rec_r.smallest;
          end
          if (!done_nxt) begin
            if (rec_r.second_smallest == '0) begin
              rec_nxt.second_smallest = val_nxt;
              done_nxt                = 1'b1;
            end else if (rec_r.second_smallest > val_nxt) begin
              rec_nxt.second_smallest = val_nxt;
              val_nxt                 = rec_r.second_smallest;
            end
          end
          if (!done_nxt) begin
            rec_nxt.trimmed_total = rec_r.trimmed_total + val_nxt;
          end
        end
      end
      tip_pkg::B_FIN: begin
        if (!out_valid_r || out_chan.ready) begin
          ram_we        = work_r.hit && (work_r.kind != tip_pkg::KIND_READ);
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{
            call_count:      rec_r.call_count,
            trimmed_total:   rec_r.trimmed_total,
            largest:         rec_r.largest,
            second_largest:  rec_r.second_largest,
            smallest:        rec_r.smallest,
            second_smallest: rec_r.second_smallest
          };
          state_nxt     = tip_pkg::B_IDLE;
        end
      end
      default: begin
        state_nxt = tip_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tip_pkg::B_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r     <= work_nxt;
    rec_r      <= rec_nxt;
    val_r      <= val_nxt;
    done_r     <= done_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_chan.valid  = out_valid_r;
  assign out_chan.data   = out_data_r;
  assign stat.clearing   = state_r == tip_pkg::B_CLEAR;
  assign stat.finishing  = state_r == tip_pkg::B_FIN;

endmodule

### rtl/trimmed_interval_profiler_core.sv
// ============================================================================
// Trimmed interval profiler core
// Per-channel begin/end interval profiler with two largest and two smallest
// trim slots per channel and a wrapping trimmed total.
//
//   Channel   Port      Beat type          Direction
//   events    in_chan   tip_pkg::in_beat_t  in
//   records   out_chan  tip_pkg::out_beat_t out
//
// The back end handles one event at a time through the record RAM read port.
// A begin or read event passes through the load and finish states, an end event
// also through the two slot states; an off-table channel goes straight to finish.
// Reset is synchronous; after it a clearing pass zeroes the record RAM, during
// which no event beat is taken. The finish state waits out any output stall.
// A two-entry queue lets the input side take up to two beats while results stall.
// ============================================================================
`include "trimmed_interval_profiler_core_defines.svh"

module trimmed_interval_profiler_core #(
  parameter int ENTRIES = tip_pkg::ENTRIES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  tip_chan_if.sink   in_chan,
  tip_chan_if.source out_chan
);

  tip_pkg::back_stat_t stat;

  tip_chan_if #(.payload_t(tip_pkg::work_t)) work_in ();
  tip_chan_if #(.payload_t(tip_pkg::work_t)) work_q ();

  tip_front #(
    .ENTRIES (ENTRIES)
  ) u_front (
    .in_chan   (in_chan),
    .work_chan (work_in),
    .stat      (stat)
  );

  tip_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_chan (work_in),
    .pop_chan  (work_q)
  );

  tip_back #(
    .ENTRIES (ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .work_chan (work_q),
    .out_chan  (out_chan),
    .stat      (stat)
  );

  `TIP_ASSERT_IMP(a_no_accept_in_clear, clk, rst_n, stat.clearing, !in_chan.ready)
  `TIP_ASSERT_IMP(a_queue_empty_in_clear, clk, rst_n, stat.clearing, !work_q.valid)
  `TIP_ASSERT_IMP(a_result_from_fin, clk, rst_n, $rose(out_chan.valid), $past(stat.finishing))
  `TIP_ASSERT_NXT(a_fin_leaves_clear, clk, rst_n, stat.finishing, !stat.clearing)

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// Trimmed interval profiler testbench
// Drives begin, end and read events into the profiler core and checks every
// returned record against a cycle-free model of the per-channel table, under
// several idle mixes on both channels and one long output hold-off.
// ============================================================================
module tb;

  localparam int          N_CHAN      = tip_pkg::ENTRIES_DEF;
  localparam int          CW          = tip_pkg::CHAN_W;
  localparam int          SW          = tip_pkg::STAMP_W;
  localparam int          STALL_LIMIT = 2000;
  localparam int          HOLD_CYCLES = 60;
  localparam int          DRAIN_WAIT  = 20;
  localparam logic [1:0]  OPC_READ    = 2'd2;
  localparam logic [1:0]  OPC_SPARE   = 2'd3;

  logic clk = 1'b0;
  logic rst_n;

  tip_chan_if #(.payload_t(tip_pkg::in_beat_t))  in_if ();
  tip_chan_if #(.payload_t(tip_pkg::out_beat_t)) out_if ();

  trimmed_interval_profiler_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  logic [SW-1:0] ch_start [N_CHAN];
  logic [SW-1:0] ch_calls [N_CHAN];
  logic [SW-1:0] ch_total [N_CHAN];
  logic [SW-1:0] top_slot [2*N_CHAN];
  logic [SW-1:0] low_slot [2*N_CHAN];

  tip_pkg::out_beat_t pending_records [$];
  tip_pkg::out_beat_t want;

  int send_idle_pct;
  int recv_idle_pct;
  int hold_req;
  int hold_left;
  int idle_cycles;
  int errors;
  int n_begin;
  int n_end;
  int n_read;
  int n_records;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic tip_pkg::out_beat_t profile_event(tip_pkg::in_beat_t ev);
    logic [SW-1:0]      v;
    logic [SW-1:0]      s;
    int                 c;
    int                 base;
    bit                 placed;
    tip_pkg::out_beat_t r;
    c = int'(ev.channel);
    r = '0;
    if (c < N_CHAN) begin
      base = 2 * c;
      if (ev.opcode == tip_pkg::OPC_BEGIN) begin
        ch_start[c] = ev.timestamp;
      end else if (ev.opcode == tip_pkg::OPC_END) begin
        v = ev.timestamp - ch_start[c];
        ch_calls[c] = ch_calls[c] + 64'd1;
        placed = 1'b0;
        for (int i = 0; i < 2; i++) begin
          if (!placed) begin
            s = top_slot[base+i];
            if (s == '0) begin
              top_slot[base+i] = v;
              placed = 1'b1;
            end else if (s < v) begin
              top_slot[base+i] = v;
              v = s;
            end
          end
        end
        for (int i = 0; i < 2; i++) begin
          if (!placed) begin
            s = low_slot[base+i];
            if (s == '0) begin
              low_slot[base+i] = v;
              placed = 1'b1;
            end else if (s > v) begin
              low_slot[base+i] = v;
              v = s;
            end
          end
        end
        if (!placed) begin
          ch_total[c] = ch_total[c] + v;
        end
      end
      r.call_count      = ch_calls[c];
      r.trimmed_total   = ch_total[c];
      r.largest         = top_slot[base];
      r.second_largest  = top_slot[base+1];
      r.smallest        = low_slot[base];
      r.second_smallest = low_slot[base+1];
    end
    return r;
  endfunction

  function automatic logic [SW-1:0] random_stamp();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [SW-1:0] random_elapsed();
    logic [SW-1:0] e;
    case ($urandom_range(9))
      0: e = '0;
      1, 2, 3, 4: e = 64'($urandom_range(2000, 1));
      5, 6: e = {32'h0, $urandom};
      default: e = random_stamp();
    endcase
    return e;
  endfunction

  task automatic send_beat(input logic [1:0] op, input logic [CW-1:0] ch,
                           input logic [SW-1:0] ts);
    tip_pkg::in_beat_t b;
    b.opcode    = op;
    b.channel   = ch;
    b.timestamp = ts;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= b;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    pending_records.push_back(profile_event(b));
    case (op)
      tip_pkg::OPC_BEGIN: n_begin++;
      tip_pkg::OPC_END:   n_end++;
      default:            n_read++;
    endcase
  endtask

  task automatic report_field(input string name, input logic [SW-1:0] exp_v,
                              input logic [SW-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t ns: %s expected %h, actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      n_records++;
      if (pending_records.size() == 0) begin
        $display("%0t ns: record beat with nothing expected, actual %h", $time,
                 out_if.data);
        errors++;
      end else begin
        want = pending_records.pop_front();
        report_field("call_count", want.call_count, out_if.data.call_count);
        report_field("trimmed_total", want.trimmed_total, out_if.data.trimmed_total);
        report_field("largest", want.largest, out_if.data.largest);
        report_field("second_largest", want.second_largest, out_if.data.second_largest);
        report_field("smallest", want.smallest, out_if.data.smallest);
        report_field("second_smallest", want.second_smallest,
                     out_if.data.second_smallest);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t ns: watchdog expired with %0d records outstanding", $time,
               pending_records.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic test_empty_reads();
    send_beat(OPC_READ, 7'd0, '0);
    send_beat(OPC_SPARE, 7'd127, '1);
  endtask

  task automatic test_stamp_extremes();
    send_beat(tip_pkg::OPC_END, 7'd127, '1);
    send_beat(tip_pkg::OPC_BEGIN, 7'd0, '1);
    send_beat(tip_pkg::OPC_END, 7'd0, '0);
    send_beat(tip_pkg::OPC_BEGIN, 7'd1, 64'd5);
    send_beat(tip_pkg::OPC_END, 7'd1, 64'd5);
    send_beat(tip_pkg::OPC_BEGIN, 7'd3, 64'hffff_ffff_0000_0000);
    send_beat(tip_pkg::OPC_END, 7'd3, 64'h0000_0000_ffff_ffff);
  endtask

  task automatic test_slot_cascade();
    logic [SW-1:0] stops [9];
    stops = '{64'd100, 64'd300, 64'd200, 64'd50, 64'd400, 64'd10, 64'd250,
              64'd250, 64'd0};
    send_beat(tip_pkg::OPC_BEGIN, 7'd2, '0);
    foreach (stops[i]) send_beat(tip_pkg::OPC_END, 7'd2, stops[i]);
    send_beat(OPC_READ, 7'd2, random_stamp());
    send_beat(OPC_SPARE, 7'd2, random_stamp());
  endtask

  task automatic test_random_traffic(input int n_items);
    int            sent;
    logic [CW-1:0] ch;
    logic [SW-1:0] t0;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 70) begin
        ch = ($urandom_range(99) < 60) ? CW'($urandom_range(7)) :
                                         CW'($urandom_range(N_CHAN-1));
        t0 = random_stamp();
        send_beat(tip_pkg::OPC_BEGIN, ch, t0);
        send_beat(tip_pkg::OPC_END, ch, t0 + random_elapsed());
        if ($urandom_range(9) == 0) send_beat(OPC_READ, ch, random_stamp());
        sent += 2;
      end else begin
        send_beat(2'($urandom_range(3)), CW'($urandom_range(N_CHAN-1)),
                  random_stamp());
        sent++;
      end
    end
  endtask

  task automatic test_output_hold();
    hold_req = HOLD_CYCLES;
    test_random_traffic(24);
  endtask

  initial begin
    in_if.valid   = 1'b0;
    in_if.data    = '0;
    out_if.ready  = 1'b0;
    rst_n         = 1'b0;
    send_idle_pct = 23;
    recv_idle_pct = 64;
    hold_req      = 0;
    hold_left     = 0;
    idle_cycles   = 0;
    errors        = 0;
    n_begin       = 0;
    n_end         = 0;
    n_read        = 0;
    n_records     = 0;
    for (int i = 0; i < N_CHAN; i++) begin
      ch_start[i] = '0;
      ch_calls[i] = '0;
      ch_total[i] = '0;
    end
    for (int i = 0; i < 2*N_CHAN; i++) begin
      top_slot[i] = '0;
      low_slot[i] = '0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_reads();
    test_stamp_extremes();
    test_slot_cascade();
    test_random_traffic(300);
    send_idle_pct = 64;
    recv_idle_pct = 23;
    test_random_traffic(300);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(280);
    test_output_hold();
    @(negedge clk);
    in_if.valid <= 1'b0;

    while (pending_records.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Covered %0d begin, %0d end and %0d read beats; %0d records checked.",
             n_begin, n_end, n_read, n_records);
    $display("Three idle mixes and a %0d-cycle output hold-off; %0d field errors.",
             HOLD_CYCLES, errors);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
